FILE: design/lidar_range_frame_parser_top_macros.svh
// ----------------------------------------------------------------------------
// Lidar range frame parser assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef LIDAR_RANGE_FRAME_PARSER_TOP_MACROS_SVH
`define LIDAR_RANGE_FRAME_PARSER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define LRFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define LRFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/lrfp_pkg.sv
// ----------------------------------------------------------------------------
// Lidar range frame parser package
// Shared constants, status codes and types.
// ----------------------------------------------------------------------------
package lrfp_pkg;

    localparam int WIN_LEN = 9;

    localparam logic [7:0]  HEADER_RESET       = 8'h59;
    localparam logic [15:0] MIN_STRENGTH_RESET = 16'd100;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEADER  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN_STR = 4'd1;

    localparam logic [1:0] STATUS_VALID = 2'd0;
    localparam logic [1:0] STATUS_WEAK  = 2'd1;
    localparam logic [1:0] STATUS_CKSUM = 2'd2;

    localparam int OUT_DATA_W = 40;

    typedef struct packed {
        logic [7:0]  header_value;
        logic [15:0] min_strength;
    } cfg_t;

    typedef struct packed {
        logic [15:0] signal_strength;
        logic [15:0] range_cm;
        logic [1:0]  frame_status;
    } result_t;

endpackage

FILE: design/lrfp_frame_core.sv
// ----------------------------------------------------------------------------
// Lidar range frame parser window core
// Holds the byte window and fill count, examines a full frame in one pass.
// ----------------------------------------------------------------------------
module lrfp_frame_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_valid,
    input  logic [7:0]       byte_data,
    input  lrfp_pkg::cfg_t   cfg,
    output logic             res_valid,
    output lrfp_pkg::result_t res
);
    import lrfp_pkg::*;

    localparam logic [3:0] FILL_FULL = 4'(WIN_LEN - 1);

    logic [7:0] win_reg  [0:WIN_LEN-2];
    logic [7:0] win_next [0:WIN_LEN-2];
    logic [3:0] fill_reg;
    logic [3:0] fill_next;

    logic [7:0] frame [0:WIN_LEN-1];

    always_comb
    begin
        for (int i = 0; i < WIN_LEN - 1; i++)
        begin
            frame[i] = win_reg[i];
        end
        frame[WIN_LEN-1] = byte_data;
    end

    always_comb
    begin
        logic       hdr_ok;
        logic [3:0] pos;
        logic [3:0] src;
        logic [7:0] sum;
        logic [15:0] range_word;
        logic [15:0] str;

        hdr_ok = (frame[0] == cfg.header_value) && (frame[1] == cfg.header_value);
        src    = 4'd0;

        // first header byte at position one or later; none found leaves nine
        pos = 4'(WIN_LEN);
        for (int i = WIN_LEN - 1; i >= 1; i--)
        begin
            if (frame[i] == cfg.header_value)
            begin
                pos = 4'(i);
            end
        end

        sum = 8'd0;
        for (int i = 0; i < WIN_LEN - 1; i++)
        begin
            sum = sum + frame[i];
        end

        range_word = {frame[3], frame[2]};
        str        = {frame[5], frame[4]};

        for (int j = 0; j < WIN_LEN - 1; j++)
        begin
            win_next[j] = win_reg[j];
        end
        fill_next = fill_reg;
        res_valid = 1'b0;
        res       = '0;

        if (fill_reg != FILL_FULL)
        begin
            win_next[fill_reg[2:0]] = byte_data;
            fill_next = fill_reg + 4'd1;
        end
        else if (!hdr_ok)
        begin
            // drop leading bytes up to the next header byte
            for (int j = 0; j < WIN_LEN - 1; j++)
            begin
                src = 4'(j) + pos;
                if (src <= 4'(WIN_LEN - 1))
                begin
                    win_next[j] = frame[src];
                end
            end
            fill_next = 4'(WIN_LEN) - pos;
        end
        else if (sum != frame[WIN_LEN-1])
        begin
            // drop one byte and report the mismatch
            for (int j = 0; j < WIN_LEN - 1; j++)
            begin
                win_next[j] = frame[j+1];
            end
            fill_next = FILL_FULL;
            res_valid = 1'b1;
            res.frame_status = STATUS_CKSUM;
        end
        else
        begin
            fill_next           = 4'd0;
            res_valid           = 1'b1;
            res.range_cm        = range_word;
            res.signal_strength = str;
            res.frame_status    = ((str < cfg.min_strength) || (range_word == 16'd0))
                                  ? STATUS_WEAK : STATUS_VALID;
        end

        if (!byte_valid)
        begin
            res_valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 4'd0;
        end
        else if (byte_valid)
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid)
        begin
            for (int j = 0; j < WIN_LEN - 1; j++)
            begin
                win_reg[j] <= win_next[j];
            end
        end
    end

endmodule

FILE: design/lrfp_out_reg.sv
// ----------------------------------------------------------------------------
// Lidar range frame parser output register
// Holds one result transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
module lrfp_out_reg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  lrfp_pkg::result_t                   res,
    output logic                                free,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lrfp_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import lrfp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (free)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {(OUT_DATA_W - $bits(result_t))'(0), res_reg};

endmodule

FILE: design/lidar_range_frame_parser_top.sv
// A result is presented on m_tdata after the byte transaction that completes its frame
// is captured in the input register and then loaded into the output register.
// Throughput: one byte per cycle while the output register is free; the window update and
// frame check run in a single pass between the input register and the output register.
// Reset: fill count cleared, registers return to header 0x59 and strength 100;
// the window data itself is not cleared and no clearing pass is needed.
// ----------------------------------------------------------------------------
// Lidar range frame parser top level
// Rebuilds rangefinder frames from a serial byte stream and reports readings.
// ----------------------------------------------------------------------------
module lidar_range_frame_parser_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // s_tdata: [7:0] rx_byte
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,
    // m_tdata: [1:0] frame_status, [17:2] range_cm, [33:18] signal_strength,
    // [39:34] zero
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lrfp_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lrfp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lrfp_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import lrfp_pkg::*;

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       out_free;
    logic       proceed;
    logic       res_valid;
    result_t    res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_value <= HEADER_RESET;
            cfg_reg.min_strength <= MIN_STRENGTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IDX_HEADER:  cfg_reg.header_value <= cfg_data[7:0];
                CFG_IDX_MIN_STR: cfg_reg.min_strength <= cfg_data;
                default:         ;
            endcase
        end
    end

    // advance the held byte only when the output register can take a result
    assign proceed  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (proceed)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    lrfp_frame_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (proceed),
        .byte_data  (in_byte_reg),
        .cfg        (cfg_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    lrfp_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_valid),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: design/lrfp_checker.sv
// ----------------------------------------------------------------------------
// Lidar range frame parser port checker
// Watches the result stream of the top level for malformed transactions.
// ----------------------------------------------------------------------------
`include "lidar_range_frame_parser_top_macros.svh"

module lrfp_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [lrfp_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import lrfp_pkg::*;

    `LRFP_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    `LRFP_ASSERT_NOW(a_status_code, clk, rst_n, m_tvalid, m_tdata[1:0] == STATUS_VALID || m_tdata[1:0] == STATUS_WEAK || m_tdata[1:0] == STATUS_CKSUM, "unknown frame status")

    `LRFP_ASSERT_NOW(a_cksum_zero, clk, rst_n, m_tvalid && m_tdata[1:0] == STATUS_CKSUM, m_tdata[33:2] == 32'd0, "checksum result carries a reading")

    `LRFP_ASSERT_NOW(a_valid_nonzero, clk, rst_n, m_tvalid && m_tdata[1:0] == STATUS_VALID, m_tdata[17:2] != 16'd0, "zero distance reported as valid")

endmodule

bind lidar_range_frame_parser_top lrfp_checker u_checker (.*);

FILE: tb/lidar_range_frame_parser_top_tb.sv
// ----------------------------------------------------------------------------
// Lidar range frame parser testbench
// Streams serial bytes into the parser and checks every reading it reports
// against a byte-level frame predictor. Covers directed frames, register
// writes, a long random stream and a stretch of output backpressure.
// ----------------------------------------------------------------------------
module lidar_range_frame_parser_top_tb;

    import lrfp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_LO = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_HI = 4'd15;
    localparam int PHASE_BYTES = 235;

    typedef enum logic [1:0] {READY_ALWAYS, READY_RANDOM, READY_PERIODIC} ready_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // frame predictor state and its copy of the registers
    logic [7:0]  rx_window [WIN_LEN];
    int          rx_fill = 0;
    logic [7:0]  hdr_reg = HEADER_RESET;
    logic [15:0] min_str_reg = MIN_STRENGTH_RESET;
    result_t     pending_readings [$];

    int          error_count = 0;
    int          bytes_sent = 0;
    int          burst_left = 0;
    bit          sender_steady = 1'b0;
    ready_mode_t ready_mode = READY_ALWAYS;
    int          hold_left = 0;
    int          ready_cycle = 0;

    lidar_range_frame_parser_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("lidar_range_frame_parser_top_tb: errors");
        $finish;
    end

    function automatic void drop_window_front(input int n);
        if (n >= rx_fill)
        begin
            rx_fill = 0;
            return;
        end
        for (int i = 0; i < rx_fill - n; i++)
            rx_window[i] = rx_window[i + n];
        rx_fill = rx_fill - n;
    endfunction

    // Append one byte and queue the reading it completes, if any
    function automatic void parse_rx_byte(input logic [7:0] rx);
        int          pos;
        logic [7:0]  sum;
        logic [15:0] range_cm;
        logic [15:0] strength_val;
        result_t     rd;
        if (rx_fill >= WIN_LEN)
            rx_fill = 0;
        rx_window[rx_fill] = rx;
        rx_fill++;
        if (rx_fill < WIN_LEN)
            return;
        if (rx_window[0] != hdr_reg || rx_window[1] != hdr_reg)
        begin
            // resync on the next header byte, or clear the window
            pos = WIN_LEN;
            for (int i = WIN_LEN - 1; i >= 1; i--)
                if (rx_window[i] == hdr_reg)
                    pos = i;
            drop_window_front(pos);
            return;
        end
        sum = '0;
        for (int i = 0; i < WIN_LEN - 1; i++)
            sum = sum + rx_window[i];
        if (sum != rx_window[WIN_LEN - 1])
        begin
            drop_window_front(1);
            rd.frame_status    = STATUS_CKSUM;
            rd.range_cm        = '0;
            rd.signal_strength = '0;
            pending_readings.push_back(rd);
            return;
        end
        range_cm     = {rx_window[3], rx_window[2]};
        strength_val = {rx_window[5], rx_window[4]};
        rx_fill = 0;
        rd.frame_status    = (strength_val < min_str_reg || range_cm == '0) ?
                             STATUS_WEAK : STATUS_VALID;
        rd.range_cm        = range_cm;
        rd.signal_strength = strength_val;
        pending_readings.push_back(rd);
    endfunction

    // Receiver: long hold first, then the selected stall pattern
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else
        begin
            case (ready_mode)
                READY_ALWAYS: m_tready <= 1'b1;
                READY_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
                default:      m_tready <= ((ready_cycle % 11) < 6);
            endcase
        end
        ready_cycle++;
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[$bits(result_t)-1:0]);
            if (pending_readings.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected reading transaction: tdata=%h", m_tdata);
            end
            else
            begin
                want = pending_readings.pop_front();
                if (got.frame_status !== want.frame_status ||
                    got.range_cm !== want.range_cm ||
                    got.signal_strength !== want.signal_strength ||
                    m_tdata[OUT_DATA_W-1:$bits(result_t)] !== '0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: status %0d/%0d range %0d/%0d %s %0d/%0d pad %h",
                                 want.frame_status, got.frame_status,
                                 want.range_cm, got.range_cm, "strength",
                                 want.signal_strength, got.signal_strength,
                                 m_tdata[OUT_DATA_W-1:$bits(result_t)]);
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] rx);
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        do
            @(posedge clk);
        while (!s_tready);
        parse_rx_byte(rx);
        bytes_sent++;
        @(negedge clk);
        if (!sender_steady)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                burst_left = $urandom_range(0, 16);
            end
        end
    endtask

    // Build a frame with a correct checksum xor ck_flip; send its first len bytes
    task automatic send_frame(input logic [7:0] h0, input logic [7:0] h1,
                              input logic [15:0] range_cm, input logic [15:0] strength_val,
                              input logic [15:0] tail, input logic [7:0] ck_flip,
                              input int len);
        logic [7:0] frame [WIN_LEN];
        logic [7:0] sum;
        frame[0] = h0;
        frame[1] = h1;
        frame[2] = range_cm[7:0];
        frame[3] = range_cm[15:8];
        frame[4] = strength_val[7:0];
        frame[5] = strength_val[15:8];
        frame[6] = tail[7:0];
        frame[7] = tail[15:8];
        sum = '0;
        for (int i = 0; i < WIN_LEN - 1; i++)
            sum = sum + frame[i];
        frame[WIN_LEN - 1] = sum ^ ck_flip;
        for (int i = 0; i < len; i++)
            send_byte(frame[i]);
    endtask

    // Drop the input, drain readings, then let the pipeline empty
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        settle_block();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_IDX_HEADER)
            hdr_reg = val[7:0];
        else if (idx == CFG_IDX_MIN_STR)
            min_str_reg = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_frames();
        ready_mode = READY_RANDOM;
        send_frame(hdr_reg, hdr_reg, 16'hFFFF, 16'hFFFF, 16'h0000, 8'h00, WIN_LEN);
        send_frame(hdr_reg, hdr_reg, 16'h0000, 16'h0000, 16'hFFFF, 8'h00, WIN_LEN);
        // bad checksum leaves eight bytes; one more byte finds no header and clears
        send_frame(hdr_reg, hdr_reg, 16'h1234, 16'h0050, 16'h0000, 8'h01, WIN_LEN);
        send_byte(8'h00);
    endtask

    task automatic test_config_registers();
        ready_mode = READY_PERIODIC;
        write_reg(CFG_IDX_MIN_STR, 16'h0000);
        send_frame(hdr_reg, hdr_reg, 16'd5, 16'd0, 16'h0000, 8'h00, WIN_LEN);
        // upper byte of the header write must be masked off
        write_reg(CFG_IDX_HEADER, 16'hAB00);
        send_frame(8'h00, 8'h00, 16'h0101, 16'h0202, 16'h0303, 8'h00, WIN_LEN);
        write_reg(CFG_IDX_UNUSED_LO, 16'h5959);
        write_reg(CFG_IDX_UNUSED_HI, 16'hFFFF);
        send_frame(8'h00, 8'h00, 16'h0700, 16'h0001, 16'h0000, 8'h00, WIN_LEN);
        write_reg(CFG_IDX_MIN_STR, 16'hFFFF);
        send_frame(hdr_reg, hdr_reg, 16'd7, 16'hFFFE, 16'h5A5A, 8'h00, WIN_LEN);
        send_frame(hdr_reg, hdr_reg, 16'd7, 16'hFFFF, 16'hA5A5, 8'h00, WIN_LEN);
        write_reg(CFG_IDX_HEADER, 16'h00FF);
        send_frame(8'hFF, 8'hFF, 16'h8000, 16'hFFFF, 16'h00FF, 8'h00, WIN_LEN);
    endtask

    task automatic test_random_stream();
        int          phase_end;
        int          n;
        logic [15:0] range_cm;
        logic [15:0] strength_val;
        logic [7:0]  flip;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(CFG_IDX_HEADER, 16'($urandom));
                    write_reg(CFG_IDX_MIN_STR, 16'($urandom));
                    ready_mode    = READY_ALWAYS;
                    sender_steady = 1'b0;
                end
                1:
                begin
                    write_reg(CFG_IDX_HEADER, 16'(HEADER_RESET));
                    write_reg(CFG_IDX_MIN_STR, MIN_STRENGTH_RESET);
                    ready_mode = READY_RANDOM;
                end
                2:
                begin
                    write_reg(CFG_IDX_HEADER, 16'h0000);
                    write_reg(CFG_IDX_MIN_STR, 16'h0000);
                    ready_mode    = READY_PERIODIC;
                    sender_steady = 1'b1;
                end
                default:
                begin
                    write_reg(CFG_IDX_HEADER, 16'h00FF);
                    write_reg(CFG_IDX_MIN_STR, 16'hFFFF);
                    ready_mode    = READY_RANDOM;
                    sender_steady = 1'b0;
                end
            endcase
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end)
            begin
                case ($urandom_range(0, 5))
                    0:       range_cm = 16'h0000;
                    1:       range_cm = 16'hFFFF;
                    default: range_cm = 16'($urandom);
                endcase
                // bias strength toward the weak threshold
                case ($urandom_range(0, 6))
                    0:       strength_val = min_str_reg;
                    1:       strength_val = min_str_reg - 16'd1;
                    2:       strength_val = min_str_reg + 16'd1;
                    3:       strength_val = 16'h0000;
                    4:       strength_val = 16'hFFFF;
                    default: strength_val = 16'($urandom);
                endcase
                flip = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5:
                        send_frame(hdr_reg, hdr_reg, range_cm, strength_val,
                                   16'($urandom), flip, WIN_LEN);
                    6:
                        send_frame(hdr_reg, 8'($urandom), range_cm, strength_val,
                                   16'($urandom), flip, WIN_LEN);
                    7:
                        send_frame(hdr_reg, hdr_reg, range_cm, strength_val,
                                   16'($urandom), flip, $urandom_range(1, WIN_LEN - 1));
                    8:
                    begin
                        n = $urandom_range(1, 6);
                        for (int i = 0; i < n; i++)
                            send_byte(8'($urandom));
                    end
                    default:
                    begin
                        n = $urandom_range(1, 6);
                        for (int i = 0; i < n; i++)
                            send_byte(($urandom_range(0, 2) == 0) ? hdr_reg : 8'($urandom));
                    end
                endcase
            end
        end
        sender_steady = 1'b0;
    endtask

    task automatic test_backpressure();
        write_reg(CFG_IDX_HEADER, 16'(HEADER_RESET));
        write_reg(CFG_IDX_MIN_STR, MIN_STRENGTH_RESET);
        ready_mode    = READY_ALWAYS;
        sender_steady = 1'b1;
        // hold the output long enough for the parser to stall its input
        hold_left = 200;
        for (int i = 0; i < 6; i++)
            send_frame(hdr_reg, hdr_reg, 16'($urandom), 16'($urandom),
                       16'($urandom), 8'h00, WIN_LEN);
        // a run of header bytes fails the checksum on every byte once the window is full
        repeat (30) send_byte(hdr_reg);
        sender_steady = 1'b0;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_frames();
        test_config_registers();
        test_random_stream();
        test_backpressure();
        settle_block();
        repeat (10) @(negedge clk);
        if (error_count == 0 && pending_readings.size() == 0)
            $display("lidar_range_frame_parser_top_tb: clean");
        else
            $display("lidar_range_frame_parser_top_tb: errors");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/lrfp_pkg.sv
design/lrfp_frame_core.sv
design/lrfp_out_reg.sv
design/lidar_range_frame_parser_top.sv
design/lrfp_checker.sv
tb/lidar_range_frame_parser_top_tb.sv
